/* rtl/dwdu_pkg.sv */
// Package: constants, types and the divider step for the winding diffusion update core.
package dwdu_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_SIDE   = 4096;
  localparam int VAL_W      = 32;
  localparam int COORD_W    = 12;
  localparam int DAMP_W     = 17;
  localparam int DAMP_BITS  = 16;
  localparam int DAMP_ONE   = 65536;
  localparam int CFG_IDX_W  = 2;
  localparam int TERM_W     = 36;
  localparam int WGT_W      = 4;
  localparam int REM_W      = 3;
  localparam int DIV_STAGES = 6;
  localparam int DIV_STEPS  = TERM_W / DIV_STAGES;
  localparam int MEAN_W     = 34;
  localparam int MIX_W      = 52;
  localparam int N_TERMS    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUT_COLUMN = 2'd0,
    CFG_CUT_ROW    = 2'd1,
    CFG_DAMPING    = 2'd2
  } cfg_reg_t;

  typedef logic signed [TERM_W-1:0] term_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] old;
    logic                    upd;
    logic                    neg;
    logic [WGT_W-1:0]        weight;
  } side_t;

  typedef struct packed {
    logic [TERM_W-1:0] dq;
    logic [REM_W-1:0]  rem;
  } div_t;

  function automatic div_t div_steps(div_t a, logic [WGT_W-1:0] w);
    div_t           r;
    logic [REM_W:0] t;
    logic           qbit;
    r = a;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t    = {r.rem, r.dq[TERM_W-1]};
      qbit = (t >= w);
      if (qbit) begin
        r.rem = REM_W'(t - w);
      end else begin
        r.rem = t[REM_W-1:0];
      end
      r.dq = {r.dq[TERM_W-2:0], qbit};
    end
    return r;
  endfunction

endpackage

/* rtl/dwdu_if.sv */
// Interfaces: input pixel channel and result channel of the winding diffusion update core.
interface dwdu_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  center_value;
  logic                center_valid;
  logic signed [31:0]  below_value;
  logic signed [31:0]  above_value;
  logic signed [31:0]  right_value;
  logic signed [31:0]  left_value;
  logic [3:0]          neighbor_valid;
  logic [11:0]         pixel_column;
  logic [11:0]         pixel_row;
  logic signed [31:0]  inner_partner_value;
  logic signed [31:0]  outer_partner_value;
  logic [1:0]          partner_valid;

  modport source (
    output valid, center_value, center_valid, below_value, above_value, right_value,
           left_value, neighbor_valid, pixel_column, pixel_row, inner_partner_value,
           outer_partner_value, partner_valid,
    input  ready
  );
  modport sink (
    input  valid, center_value, center_valid, below_value, above_value, right_value,
           left_value, neighbor_valid, pixel_column, pixel_row, inner_partner_value,
           outer_partner_value, partner_valid,
    output ready
  );
endinterface

interface dwdu_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  new_value;
  logic                was_updated;

  modport source (output valid, new_value, was_updated, input ready);
  modport sink (input valid, new_value, was_updated, output ready);
endinterface

/* rtl/damped_winding_diffusion_update_core.sv */
// Top level: pipelined damped 4-neighbor relaxation update for one winding-map pixel.
//
// Usage: one pixel per transfer on in_ch (valid/ready), one result per pixel on out_ch in
// the same order. The user must write registers cut_column, cut_row and damping through
// cfg_we/cfg_index/cfg_data only while no pixel is in flight; the block does not enforce it. Index 3 is ignored.
// Pipeline: term build, sum, magnitude, six long-division stages (six quotient bits
// each, the mean divides by the total weight 1..8), sign restore, two multipliers,
// then add, shift and saturate into the output register.
// Throughput: one pixel per cycle while out_ch does not stall, set by the fully pipelined datapath.
// Stall: the whole pipeline holds while out_ch.valid is high and out_ch.ready is low;
// in_ch.ready follows that hold, so nothing is lost or repeated.
// Reset (rst_n low, synchronous): all stage valid bits clear and the three
// registers return to zero; no result is presented until new pixels enter.
module damped_winding_diffusion_update_core (
  input  logic                              clk,
  input  logic                              rst_n,
  dwdu_in_if.sink                           in_ch,
  dwdu_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dwdu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dwdu_pkg::DAMP_W-1:0]       cfg_data
);
  import dwdu_pkg::*;

  localparam term_t ONE_T = term_t'(longint'(1) << FRAC_BITS);
  localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'(64'sh7FFF_FFFF);
  localparam logic signed [MIX_W-1:0] SAT_LO = MIX_W'(-64'sh8000_0000);
  localparam logic [DAMP_W-1:0] D_ONE = DAMP_W'(DAMP_ONE);

  logic [COORD_W-1:0] cut_col_r;
  logic [COORD_W-1:0] cut_row_r;
  logic [DAMP_W-1:0]  damping_r;

  logic adv;

  logic  s1_v_r;
  term_t s1_term_r [N_TERMS];
  side_t s1_side_r;
  logic  s2_v_r;
  term_t s2_sum_r;
  side_t s2_side_r;
  logic  s3_v_r;
  div_t  s3_div_r;
  side_t s3_side_r;
  logic  div_v_r    [DIV_STAGES];
  div_t  div_r      [DIV_STAGES];
  side_t div_side_r [DIV_STAGES];
  logic  s4_v_r;
  logic signed [MEAN_W-1:0] s4_mean_r;
  side_t s4_side_r;
  logic  s5_v_r;
  logic signed [MIX_W-1:0] s5_pold_r;
  logic signed [MIX_W-1:0] s5_pmean_r;
  side_t s5_side_r;
  logic  out_v_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic  out_upd_r;

  // stage 1 combinational
  logic               in_range;
  logic               cut_on;
  logic               right_fix;
  logic               left_fix;
  logic [WGT_W-1:0]   weight;
  term_t              term_nxt [N_TERMS];
  side_t              s1_side_nxt;
  // later stages
  term_t              sum_nxt;
  div_t               s3_div_nxt;
  side_t              s3_side_nxt;
  div_t               div_nxt [DIV_STAGES];
  logic [TERM_W-1:0]  quot;
  logic signed [MEAN_W-1:0] mean_nxt;
  logic [DAMP_W-1:0]  d_sat;
  logic signed [DAMP_W:0] d_old;
  logic signed [DAMP_W:0] d_mean;
  logic signed [MIX_W-1:0] mix;
  logic signed [MIX_W-1:0] shifted;
  logic signed [VAL_W-1:0] sat_val;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv && rst_n;

  always_comb begin
    in_range  = (32'(in_ch.pixel_column) < MAX_SIDE) && (32'(in_ch.pixel_row) < MAX_SIDE);
    cut_on    = in_ch.pixel_row >= cut_row_r;
    right_fix = cut_on && (({1'b0, in_ch.pixel_column} + 13'd1) == {1'b0, cut_col_r});
    left_fix  = cut_on && (in_ch.pixel_column == cut_col_r);
    weight    = WGT_W'(in_ch.neighbor_valid[0]) + WGT_W'(in_ch.neighbor_valid[1]) +
                WGT_W'(in_ch.neighbor_valid[2]) + WGT_W'(in_ch.neighbor_valid[3]) +
                (WGT_W'(in_ch.partner_valid[0]) << 1) + (WGT_W'(in_ch.partner_valid[1]) << 1);
    term_nxt[0] = in_ch.neighbor_valid[0] ? term_t'(in_ch.below_value) : '0;
    term_nxt[1] = in_ch.neighbor_valid[1] ? term_t'(in_ch.above_value) : '0;
    term_nxt[2] = in_ch.neighbor_valid[2] ?
                  term_t'(in_ch.right_value) + (right_fix ? ONE_T : term_t'(0)) : '0;
    term_nxt[3] = in_ch.neighbor_valid[3] ?
                  term_t'(in_ch.left_value) - (left_fix ? ONE_T : term_t'(0)) : '0;
    term_nxt[4] = in_ch.partner_valid[0] ?
                  (term_t'(in_ch.inner_partner_value) - ONE_T) <<< 1 : '0;
    term_nxt[5] = in_ch.partner_valid[1] ?
                  (term_t'(in_ch.outer_partner_value) + ONE_T) <<< 1 : '0;
    s1_side_nxt.old    = in_ch.center_value;
    s1_side_nxt.upd    = in_ch.center_valid && in_range && (weight != '0);
    s1_side_nxt.neg    = 1'b0;
    s1_side_nxt.weight = weight;
  end

  always_comb begin
    sum_nxt = s1_term_r[0] + s1_term_r[1] + s1_term_r[2] +
              s1_term_r[3] + s1_term_r[4] + s1_term_r[5];
    s3_side_nxt     = s2_side_r;
    s3_side_nxt.neg = s2_sum_r[TERM_W-1];
    s3_div_nxt.dq   = s2_sum_r[TERM_W-1] ? TERM_W'(-s2_sum_r) : TERM_W'(s2_sum_r);
    s3_div_nxt.rem  = '0;
    div_nxt[0] = div_steps(s3_div_r, s3_side_r.weight);
    for (int i = 1; i < DIV_STAGES; i++) begin
      div_nxt[i] = div_steps(div_r[i-1], div_side_r[i-1].weight);
    end
    quot     = div_r[DIV_STAGES-1].dq;
    mean_nxt = div_side_r[DIV_STAGES-1].neg ?
               -$signed({1'b0, quot[MEAN_W-2:0]}) : $signed({1'b0, quot[MEAN_W-2:0]});
    d_sat    = (damping_r > D_ONE) ? D_ONE : damping_r;
    d_old    = $signed({1'b0, d_sat});
    d_mean   = $signed({1'b0, D_ONE - d_sat});
    mix      = s5_pold_r + s5_pmean_r;
    shifted  = mix >>> DAMP_BITS;
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI[VAL_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO[VAL_W-1:0];
    end else begin
      sat_val = shifted[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_col_r <= '0;
      cut_row_r <= '0;
      damping_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUT_COLUMN: cut_col_r <= cfg_data[COORD_W-1:0];
        CFG_CUT_ROW:    cut_row_r <= cfg_data[COORD_W-1:0];
        CFG_DAMPING:    damping_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        div_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      div_v_r[0] <= s3_v_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_v_r[i] <= div_v_r[i-1];
      end
      s4_v_r  <= div_v_r[DIV_STAGES-1];
      s5_v_r  <= s4_v_r;
      out_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N_TERMS; i++) begin
        s1_term_r[i] <= term_nxt[i];
      end
      s1_side_r <= s1_side_nxt;
      s2_sum_r  <= sum_nxt;
      s2_side_r <= s1_side_r;
      s3_div_r  <= s3_div_nxt;
      s3_side_r <= s3_side_nxt;
      div_r[0]      <= div_nxt[0];
      div_side_r[0] <= s3_side_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_r[i]      <= div_nxt[i];
        div_side_r[i] <= div_side_r[i-1];
      end
      s4_mean_r  <= mean_nxt;
      s4_side_r  <= div_side_r[DIV_STAGES-1];
      s5_pold_r  <= MIX_W'(d_old * s4_side_r.old);
      s5_pmean_r <= MIX_W'(d_mean * s4_mean_r);
      s5_side_r  <= s4_side_r;
      out_val_r  <= s5_side_r.upd ? sat_val : s5_side_r.old;
      out_upd_r  <= s5_side_r.upd;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.new_value   = out_val_r;
  assign out_ch.was_updated = out_upd_r;

endmodule

/* dv/damped_winding_diffusion_update_core_tb.sv */
// Self-checking testbench for the damped winding diffusion update core.
module damped_winding_diffusion_update_core_tb;
  import dwdu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam longint TURN = 64'sd1 <<< FRAC_BITS;
  localparam longint SHEET_WEIGHT = 2;
  localparam longint VAL_MAX = (64'sd1 <<< 31) - 1;
  localparam longint VAL_MIN = -(64'sd1 <<< 31);
  localparam logic signed [VAL_W-1:0] TOP = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] BOTTOM = 32'sh8000_0000;

  typedef struct {
    logic signed [VAL_W-1:0] center_value;
    logic                    center_valid;
    logic signed [VAL_W-1:0] below_value;
    logic signed [VAL_W-1:0] above_value;
    logic signed [VAL_W-1:0] right_value;
    logic signed [VAL_W-1:0] left_value;
    logic [3:0]              neighbor_valid;
    logic [COORD_W-1:0]      pixel_column;
    logic [COORD_W-1:0]      pixel_row;
    logic signed [VAL_W-1:0] inner_partner_value;
    logic signed [VAL_W-1:0] outer_partner_value;
    logic [1:0]              partner_valid;
  } pixel_t;

  typedef struct {
    logic signed [VAL_W-1:0] new_value;
    logic                    was_updated;
  } winding_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DAMP_W-1:0]    cfg_data;

  dwdu_in_if  in_ch ();
  dwdu_out_if out_ch ();

  damped_winding_diffusion_update_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [COORD_W-1:0] cut_col_q;
  logic [COORD_W-1:0] cut_row_q;
  logic [DAMP_W-1:0]  damp_q;

  pixel_t      pending_q[$];
  winding_t    expected_q[$];
  pixel_t      on_bus;
  int unsigned send_gap;
  int unsigned sink_stall;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          idling_on;

  function automatic winding_t relax_pixel(pixel_t p);
    winding_t                r;
    logic signed [VAL_W-1:0] nb[4];
    longint                  acc;
    longint                  wsum;
    longint                  v;
    longint                  mean;
    longint                  d;
    longint                  mix;
    longint                  blended;
    logic                    cut_on;
    r.new_value   = p.center_value;
    r.was_updated = 1'b0;
    if (!p.center_valid || p.pixel_column >= MAX_SIDE || p.pixel_row >= MAX_SIDE) begin
      return r;
    end
    nb[0]  = p.below_value;
    nb[1]  = p.above_value;
    nb[2]  = p.right_value;
    nb[3]  = p.left_value;
    acc    = 0;
    wsum   = 0;
    cut_on = (p.pixel_row >= cut_row_q);
    for (int k = 0; k < 4; k++) begin
      if (p.neighbor_valid[k]) begin
        v = longint'(nb[k]);
        if (cut_on && k == 2 && int'(p.pixel_column) + 1 == int'(cut_col_q)) begin
          v += TURN;
        end
        if (cut_on && k == 3 && p.pixel_column == cut_col_q) begin
          v -= TURN;
        end
        acc  += v;
        wsum += 1;
      end
    end
    if (p.partner_valid[0]) begin
      acc  += (longint'(p.inner_partner_value) - TURN) * SHEET_WEIGHT;
      wsum += SHEET_WEIGHT;
    end
    if (p.partner_valid[1]) begin
      acc  += (longint'(p.outer_partner_value) + TURN) * SHEET_WEIGHT;
      wsum += SHEET_WEIGHT;
    end
    if (wsum == 0) begin
      return r;
    end
    mean = acc / wsum;
    d    = (damp_q > DAMP_ONE) ? longint'(DAMP_ONE) : longint'(damp_q);
    mix  = d * longint'(p.center_value) + (longint'(DAMP_ONE) - d) * mean;
    blended = mix >>> DAMP_BITS;
    if (blended > VAL_MAX) begin
      blended = VAL_MAX;
    end else if (blended < VAL_MIN) begin
      blended = VAL_MIN;
    end
    r.new_value   = blended[VAL_W-1:0];
    r.was_updated = 1'b1;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    if (!idling_on) begin
      return 0;
    end
    case ($urandom_range(0, 15))
      0:          return $urandom_range(12, 40);
      1, 2, 3, 4: return $urandom_range(1, 3);
      5:          return $urandom_range(4, 9);
      default:    return 0;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] near_value(logic signed [VAL_W-1:0] c);
    int offset;
    offset = int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
    case ($urandom_range(0, 11))
      0:       return TOP;
      1:       return BOTTOM;
      2, 3:    return $urandom;
      default: return c + offset;
    endcase
  endfunction

  function automatic pixel_t make_pixel();
    pixel_t p;
    int     turns;
    turns = int'($urandom_range(0, 40)) - 20;
    if ($urandom_range(0, 7) == 0) begin
      p.center_value = $urandom;
    end else begin
      p.center_value = turns * 65536 + int'($urandom_range(0, 65535));
    end
    p.center_valid        = ($urandom_range(0, 9) != 0);
    p.below_value         = near_value(p.center_value);
    p.above_value         = near_value(p.center_value);
    p.right_value         = near_value(p.center_value);
    p.left_value          = near_value(p.center_value);
    p.inner_partner_value = near_value(p.center_value + 65536);
    p.outer_partner_value = near_value(p.center_value - 65536);
    p.neighbor_valid      = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom);
    p.partner_valid       = 2'($urandom);
    case ($urandom_range(0, 7))
      0:       p.pixel_column = cut_col_q - 1'b1;
      1:       p.pixel_column = cut_col_q;
      2:       p.pixel_column = '0;
      3:       p.pixel_column = '1;
      default: p.pixel_column = 12'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       p.pixel_row = cut_row_q;
      1:       p.pixel_row = cut_row_q - 1'b1;
      2:       p.pixel_row = '0;
      3:       p.pixel_row = '1;
      default: p.pixel_row = 12'($urandom);
    endcase
    return p;
  endfunction

  task automatic stage_pixel(input pixel_t p);
    pending_q.insert(pending_q.size(), p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DAMP_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_CUT_COLUMN: cut_col_q = data[COORD_W-1:0];
      CFG_CUT_ROW:    cut_row_q = data[COORD_W-1:0];
      CFG_DAMPING:    damp_q    = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [DAMP_W-1:0] col, input logic [DAMP_W-1:0] row,
                           input logic [DAMP_W-1:0] damp);
    write_reg(CFG_CUT_COLUMN, col);
    write_reg(CFG_CUT_ROW, row);
    write_reg(CFG_DAMPING, damp);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      stage_pixel(make_pixel());
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("damped_winding_diffusion_update_core_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_q.insert(expected_q.size(), relax_pixel(on_bus));
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        on_bus = pending_q.pop_front();
        in_ch.center_value        <= on_bus.center_value;
        in_ch.center_valid        <= on_bus.center_valid;
        in_ch.below_value         <= on_bus.below_value;
        in_ch.above_value         <= on_bus.above_value;
        in_ch.right_value         <= on_bus.right_value;
        in_ch.left_value          <= on_bus.left_value;
        in_ch.neighbor_valid      <= on_bus.neighbor_valid;
        in_ch.pixel_column        <= on_bus.pixel_column;
        in_ch.pixel_row           <= on_bus.pixel_row;
        in_ch.inner_partner_value <= on_bus.inner_partner_value;
        in_ch.outer_partner_value <= on_bus.outer_partner_value;
        in_ch.partner_valid       <= on_bus.partner_valid;
        in_ch.valid               <= 1'b1;
        send_gap = idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    winding_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: new_value %0d", out_ch.new_value);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.new_value !== want.new_value) begin
            $error("new_value mismatch: expected %0d, got %0d", want.new_value,
                   out_ch.new_value);
            mismatches++;
          end
          if (out_ch.was_updated !== want.was_updated) begin
            $error("was_updated mismatch: expected %0b, got %0b", want.was_updated,
                   out_ch.was_updated);
            mismatches++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        sink_stall = idle_len();
      end
    end
  end

  initial begin
    pixel_t base;
    pixel_t p;
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_index                 = CFG_CUT_COLUMN;
    cfg_data                  = '0;
    in_ch.valid               = 1'b0;
    in_ch.center_value        = '0;
    in_ch.center_valid        = 1'b0;
    in_ch.below_value         = '0;
    in_ch.above_value         = '0;
    in_ch.right_value         = '0;
    in_ch.left_value          = '0;
    in_ch.neighbor_valid      = '0;
    in_ch.pixel_column        = '0;
    in_ch.pixel_row           = '0;
    in_ch.inner_partner_value = '0;
    in_ch.outer_partner_value = '0;
    in_ch.partner_valid       = '0;
    out_ch.ready              = 1'b0;
    cut_col_q                 = '0;
    cut_row_q                 = '0;
    damp_q                    = '0;
    mismatches                = 0;
    cycle_count               = 0;
    send_gap                  = 0;
    sink_stall                = 0;
    idling_on                 = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    queue_random(24);
    drain();

    configure(17'd100, 17'd50, 17'd16384);
    base.center_value        = 32'sd3 * 65536;
    base.center_valid        = 1'b1;
    base.below_value         = 32'sd3 * 65536 + 1000;
    base.above_value         = 32'sd3 * 65536 - 2000;
    base.right_value         = 32'sd4 * 65536;
    base.left_value          = 32'sd2 * 65536;
    base.neighbor_valid      = 4'hF;
    base.pixel_column        = 12'd10;
    base.pixel_row           = 12'd10;
    base.inner_partner_value = 32'sd4 * 65536;
    base.outer_partner_value = 32'sd2 * 65536;
    base.partner_valid       = 2'b11;
    stage_pixel(base);
    p = base; p.center_valid = 1'b0; stage_pixel(p);
    p = base; p.neighbor_valid = 4'h0; p.partner_valid = 2'b00; stage_pixel(p);
    p = base;
    p.center_value = TOP; p.below_value = TOP; p.above_value = TOP;
    p.right_value = TOP; p.left_value = TOP;
    p.inner_partner_value = TOP; p.outer_partner_value = TOP;
    stage_pixel(p);
    p.center_value = BOTTOM; p.below_value = BOTTOM; p.above_value = BOTTOM;
    p.right_value = BOTTOM; p.left_value = BOTTOM;
    p.inner_partner_value = BOTTOM; p.outer_partner_value = BOTTOM;
    stage_pixel(p);
    p.below_value = TOP; p.above_value = TOP; p.right_value = TOP; p.left_value = TOP;
    p.partner_valid = 2'b00;
    stage_pixel(p);
    // cut crossings and their row boundary
    p = base; p.partner_valid = 2'b00; p.neighbor_valid = 4'b0100;
    p.pixel_column = 12'd99; p.pixel_row = 12'd50; stage_pixel(p);
    p.pixel_row = 12'd49; stage_pixel(p);
    p.neighbor_valid = 4'b1000; p.pixel_column = 12'd100; stage_pixel(p);
    p.pixel_row = 12'd4095; stage_pixel(p);
    // truncation toward zero
    p = base; p.partner_valid = 2'b00; p.neighbor_valid = 4'b0111;
    p.below_value = -32'sd7; p.above_value = 32'sd0; p.right_value = 32'sd0;
    stage_pixel(p);
    p.below_value = 32'sd7; stage_pixel(p);
    for (int k = 0; k < 4; k++) begin
      p = base; p.partner_valid = 2'b00; p.neighbor_valid = 4'(1 << k);
      stage_pixel(p);
    end
    p = base; p.neighbor_valid = 4'h0; p.partner_valid = 2'b01; stage_pixel(p);
    p.partner_valid = 2'b10; stage_pixel(p);
    p.partner_valid = 2'b11; stage_pixel(p);
    p.partner_valid = 2'b01; p.inner_partner_value = BOTTOM; stage_pixel(p);
    p = base; p.pixel_column = 12'd0; p.pixel_row = 12'd0; stage_pixel(p);
    p.pixel_column = 12'd4095; p.pixel_row = 12'd4095; stage_pixel(p);
    queue_random(300);
    drain();

    idling_on = 1'b0;
    configure(17'd0, 17'd0, 17'd0);
    queue_random(300);
    drain();

    idling_on = 1'b1;
    configure(17'd4095, 17'd4095, 17'd65536);
    queue_random(300);
    drain();

    // damping above one saturates, upper data bits of the cut registers drop
    write_reg(CFG_UNMAPPED, 17'h1FFFF);
    configure(17'h1F123, 17'h10007, 17'h1FFFF);
    queue_random(300);
    drain();

    configure(17'($urandom_range(0, 4095)), 17'($urandom_range(0, 4095)),
              17'($urandom_range(0, 65536)));
    queue_random(400);
    drain();

    configure(17'd1, 17'd1, 17'd1);
    queue_random(250);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("damped_winding_diffusion_update_core_tb: PASS");
    end else begin
      $display("damped_winding_diffusion_update_core_tb: FAIL");
    end
    $finish;
  end

endmodule
